FILE: sv/rai_pkg.sv
// Package for the rate integrator with anti-windup.
// Holds field widths, arithmetic constants, register indexes and sequencer types.
// No dependencies.
`default_nettype none

package rai_pkg;

  localparam int AXES      = 3;
  localparam int AXIS_W    = 2;
  localparam int ERR_W     = 20;
  localparam int MASK_W    = 3;
  localparam int DT_W      = 16;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 17;
  localparam int INTEG_W   = 18;
  localparam int LIM_MAX   = 65536;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;

  // serial multiplier: parallel operand width, serial operand width
  localparam int MUL_AW    = 39;
  localparam int MUL_BW    = 20;
  localparam int PROD_W    = MUL_AW + MUL_BW;
  localparam int CNT_W     = 6;

  // attenuation constant round(2^24 / R^2), R = 400 deg/s in rad/s
  localparam logic [MUL_BW-1:0] ATT_K = 20'd344227;
  localparam logic [16:0]       ONE_Q16 = 17'h10000;

  // dt scaling: divide by 2^8 * 10^6 = 2^14 * 15625, rounding half up
  localparam logic [52:0] DIV_HALF  = 53'd128000000;
  localparam int          DIV_SHIFT = 14;
  localparam int          DIV_STEPS = 39;
  localparam int          DIV_REM_W = 14;
  localparam logic [DIV_REM_W:0] DIV_D = 15'd15625;
  localparam int          INC_W     = 26;
  localparam int          SUM_W     = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ROLL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PITCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_YAW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_ROLL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_PITCH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_YAW    = 3'd5;

  localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_NEXT,
    S_DIV,
    S_ACC,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_SQ,
    OP_ATT,
    OP_SCL,
    OP_GAIN,
    OP_DT
  } mul_op_t;

endpackage

`default_nettype wire

FILE: sv/rate_integrator_antiwindup_top.sv
// Three-axis rate integrator with anti-windup clipping, attenuation and clamp.
// One transaction at a time: in_tready is high only in idle, which follows loading of the previous result.
// Per axis: five shift-add multiplies on one shared serial multiplier,
// each followed by one operand load state, then a restoring divider by 15625.
// Synchronous active-low reset clears integrators, configuration registers, sequencer and handshake state.
// Depends on rai_pkg.
`default_nettype none

module rate_integrator_antiwindup_top
  import rai_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  // err_roll[19:0], err_pitch[39:20], err_yaw[59:40], sat_positive_mask[62:60],
  // sat_negative_mask[65:63], step_us[81:66], zero fill
  input  wire  [IN_DATA_W-1:0]      in_tdata,
  output logic                      out_tvalid,
  input  wire                       out_tready,
  // integ_roll[17:0], integ_pitch[35:18], integ_yaw[53:36], zero fill
  output logic [OUT_DATA_W-1:0]     out_tdata,
  input  wire                       cfg_we,
  input  wire  [CFG_IDX_W-1:0]      cfg_index,
  input  wire  [LIM_W-1:0]          cfg_wdata
);

  state_t  state_r, state_nxt;
  mul_op_t op_r, op_nxt;

  logic [AXIS_W-1:0]    axis_r, axis_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MUL_AW-1:0]    mul_a_r, mul_a_nxt;
  logic [MUL_AW-1:0]    mul_hi_r, mul_hi_nxt;
  logic [MUL_BW-1:0]    mul_lo_r, mul_lo_nxt;
  logic [ERR_W-1:0]     m_r, m_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_STEPS-1:0] div_dq_r, div_dq_nxt;
  logic [DIV_REM_W-1:0] div_rem_r, div_rem_nxt;
  logic                 integ_we;
  logic                 out_load;

  logic signed [ERR_W-1:0]   err_r [AXES];
  logic [MASK_W-1:0]         satp_r, satn_r;
  logic [DT_W-1:0]           step_r;
  logic [GAIN_W-1:0]         gain_r [AXES];
  logic [LIM_W-1:0]          lim_r [AXES];
  logic signed [INTEG_W-1:0] integ_r [AXES];
  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;

  logic                    in_accept;
  logic [AXIS_W-1:0]       cfg_gain_sel;
  logic [CFG_IDX_W-1:0]    cfg_lim_off;
  logic [LIM_W-1:0]        cfg_lim_sat;

  logic signed [ERR_W-1:0] e_sel, e_clip;
  logic [ERR_W-1:0]        e_bits, m_new;
  logic [MUL_AW:0]         mul_sum;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-33:0]      att_q;
  logic [16:0]             att_f;
  logic [52:0]             div_cs;
  logic [DIV_REM_W:0]      div_trial;
  logic                    div_ge;
  logic [DIV_REM_W-1:0]    div_rem_new;

  logic signed [SUM_W-1:0] acc_ext, inc_mag, inc_s, acc_sum, lim_pos, lim_neg, acc_clamp;

  assign in_accept  = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // configuration registers
  assign cfg_gain_sel = cfg_index[AXIS_W-1:0];
  assign cfg_lim_off  = cfg_index - CFG_LIM_ROLL;
  assign cfg_lim_sat  = (cfg_wdata > LIM_W'(LIM_MAX)) ? LIM_W'(LIM_MAX) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        gain_r[i] <= '0;
        lim_r[i]  <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index inside {[CFG_GAIN_ROLL:CFG_GAIN_YAW]}) begin
        gain_r[cfg_gain_sel] <= cfg_wdata[GAIN_W-1:0];
      end else if (cfg_index inside {[CFG_LIM_ROLL:CFG_LIM_YAW]}) begin
        lim_r[cfg_lim_off[AXIS_W-1:0]] <= cfg_lim_sat;
      end
    end
  end

  // hold the accepted transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      err_r[0] <= in_tdata[19:0];
      err_r[1] <= in_tdata[39:20];
      err_r[2] <= in_tdata[59:40];
      satp_r   <= in_tdata[62:60];
      satn_r   <= in_tdata[65:63];
      step_r   <= in_tdata[81:66];
    end
  end

  // clip error against saturated direction, take magnitude
  assign e_sel  = err_r[axis_r];
  assign e_clip = ((satp_r[axis_r] && (e_sel > 20'sd0)) ||
                   (satn_r[axis_r] && (e_sel < 20'sd0))) ? '0 : e_sel;
  assign e_bits = e_clip;
  assign m_new  = e_bits[ERR_W-1] ? (~e_bits + 20'd1) : e_bits;

  // shift-add multiplier step and product view
  assign mul_sum = {1'b0, mul_hi_r} + (mul_lo_r[0] ? {1'b0, mul_a_r} : '0);
  assign prod    = {mul_hi_r, mul_lo_r};

  assign att_q = prod[PROD_W-1:32];
  assign att_f = (att_q[PROD_W-33:16] == '0) ? (ONE_Q16 - {1'b0, att_q[15:0]}) : '0;

  assign div_cs      = {1'b0, prod[51:0]} + DIV_HALF;
  assign div_trial   = {div_rem_r, div_dq_r[DIV_STEPS-1]};
  assign div_ge      = (div_trial >= DIV_D);
  assign div_rem_new = div_ge ? DIV_REM_W'(div_trial - DIV_D) : div_trial[DIV_REM_W-1:0];

  // accumulate and clamp
  assign acc_ext   = {{(SUM_W-INTEG_W){integ_r[axis_r][INTEG_W-1]}}, integ_r[axis_r]};
  assign inc_mag   = {{(SUM_W-INC_W){1'b0}}, div_dq_r[INC_W-1:0]};
  assign inc_s     = neg_r ? -inc_mag : inc_mag;
  assign acc_sum   = acc_ext + inc_s;
  assign lim_pos   = {{(SUM_W-LIM_W){1'b0}}, lim_r[axis_r]};
  assign lim_neg   = -lim_pos;
  assign acc_clamp = (acc_sum > lim_pos) ? lim_pos :
                     (acc_sum < lim_neg) ? lim_neg : acc_sum;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    axis_nxt    = axis_r;
    cnt_nxt     = cnt_r;
    mul_a_nxt   = mul_a_r;
    mul_hi_nxt  = mul_hi_r;
    mul_lo_nxt  = mul_lo_r;
    m_nxt       = m_r;
    neg_nxt     = neg_r;
    div_dq_nxt  = div_dq_r;
    div_rem_nxt = div_rem_r;
    integ_we    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          axis_nxt  = '0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        m_nxt      = m_new;
        neg_nxt    = e_clip[ERR_W-1];
        mul_a_nxt  = {{(MUL_AW-ERR_W){1'b0}}, m_new};
        mul_lo_nxt = m_new;
        mul_hi_nxt = '0;
        cnt_nxt    = '0;
        op_nxt     = OP_SQ;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        mul_hi_nxt = mul_sum[MUL_AW:1];
        mul_lo_nxt = {mul_sum[0], mul_lo_r[MUL_BW-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_BW - 1)) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        mul_hi_nxt = '0;
        cnt_nxt    = '0;
        state_nxt  = S_MUL;
        case (op_r)
          OP_SQ: begin
            mul_a_nxt  = prod[MUL_AW-1:0];
            mul_lo_nxt = ATT_K;
            op_nxt     = OP_ATT;
          end
          OP_ATT: begin
            mul_a_nxt  = {{(MUL_AW-ERR_W){1'b0}}, m_r};
            mul_lo_nxt = {{(MUL_BW-17){1'b0}}, att_f};
            op_nxt     = OP_SCL;
          end
          OP_SCL: begin
            mul_a_nxt  = {{(MUL_AW-ERR_W){1'b0}}, prod[35:16]};
            mul_lo_nxt = {{(MUL_BW-GAIN_W){1'b0}}, gain_r[axis_r]};
            op_nxt     = OP_GAIN;
          end
          OP_GAIN: begin
            mul_a_nxt  = {{(MUL_AW-36){1'b0}}, prod[35:0]};
            mul_lo_nxt = {{(MUL_BW-DT_W){1'b0}}, step_r};
            op_nxt     = OP_DT;
          end
          OP_DT: begin
            div_dq_nxt  = div_cs[52:DIV_SHIFT];
            div_rem_nxt = '0;
            state_nxt   = S_DIV;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        div_dq_nxt  = {div_dq_r[DIV_STEPS-2:0], div_ge};
        div_rem_nxt = div_rem_new;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        integ_we = 1'b1;
        if (axis_r == AXIS_LAST) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_SQ;
      axis_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_a_r   <= mul_a_nxt;
    mul_hi_r  <= mul_hi_nxt;
    mul_lo_r  <= mul_lo_nxt;
    m_r       <= m_nxt;
    neg_r     <= neg_nxt;
    div_dq_r  <= div_dq_nxt;
    div_rem_r <= div_rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        integ_r[i] <= '0;
      end
    end else if (integ_we) begin
      integ_r[axis_r] <= acc_clamp[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {{(OUT_DATA_W - 3*INTEG_W){1'b0}}, integ_r[2], integ_r[1], integ_r[0]};
    end
  end

  a_accept_starts_roll : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == S_PREP) && (axis_r == '0))
    else $error("accepted transaction did not start on the roll axis");

  a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result presented without finishing all axes");

  a_integ_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r[0] <= LIM_MAX) && (integ_r[0] >= -LIM_MAX) &&
    (integ_r[1] <= LIM_MAX) && (integ_r[1] >= -LIM_MAX) &&
    (integ_r[2] <= LIM_MAX) && (integ_r[2] >= -LIM_MAX))
    else $error("integrator outside clamp range");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for rate_integrator_antiwindup_top: drives rate-error transactions,
// predicts the three clamped integrators per transaction and compares every result.
// Depends on rai_pkg and the rate_integrator_antiwindup_top RTL.
`timescale 1ns / 100ps

module tb_top;
  import rai_pkg::*;

  localparam int LATENCY     = 440;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int IN_USED_W   = 3 * ERR_W + 2 * MASK_W + DT_W;
  localparam int PHASE_ITEMS = 300;

  localparam longint unsigned SQ_SCALE = 344227;
  localparam longint unsigned Q16_ONE  = 65536;
  localparam longint unsigned STEP_DIV = 256000000;

  localparam logic [ERR_W-1:0] ERR_TOP    = 20'h7FFFF;
  localparam logic [ERR_W-1:0] ERR_BOTTOM = 20'h80000;
  localparam int               ERR_EDGE   = 28595;
  localparam logic [ERR_W-1:0] PEAK_ERR   = 20'd16510;

  localparam logic [GAIN_W-1:0]    GAIN_FULL = '1;
  localparam logic [DT_W-1:0]      STEP_FULL = '1;
  localparam logic [MASK_W-1:0]    MASK_ALL  = '1;
  localparam logic [MASK_W-1:0]    MASK_NONE = '0;
  localparam logic [LIM_W-1:0]     LIM_RAW_TOP = '1;
  localparam logic [LIM_W-1:0]     LIM_FULL    = LIM_W'(LIM_MAX);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef logic signed [INTEG_W-1:0] integ_t;
  typedef logic [AXES-1:0][INTEG_W-1:0] integ_vec_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [LIM_W-1:0]      cfg_wdata  = '0;

  integ_t            integ_acc  [AXES];
  logic [GAIN_W-1:0] axis_gain  [AXES];
  logic [LIM_W-1:0]  axis_limit [AXES];
  integ_vec_t        expected_integ [$];
  string             integ_name [AXES] = '{"integ_roll", "integ_pitch", "integ_yaw"};

  int fail_count   = 0;
  int tx_gap_max   = 8;
  int rx_stall_max = 8;
  int rx_hold      = 0;
  int cycle_count  = 0;

  rate_integrator_antiwindup_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rate_integrator_antiwindup_top: mismatch");
    $finish;
  end

  function automatic integ_t integrate_axis(integ_t acc, logic signed [ERR_W-1:0] err,
                                            logic sat_pos, logic sat_neg,
                                            logic [GAIN_W-1:0] gain,
                                            logic [LIM_W-1:0] limit,
                                            logic [DT_W-1:0] step);
    longint e;
    longint bound;
    longint total;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned atten;
    longint unsigned scaled;
    longint unsigned incr;
    e = err;
    if (sat_pos && e > 0) e = 0;
    if (sat_neg && e < 0) e = 0;
    mag = (e < 0) ? -e : e;
    sq = (mag * mag * SQ_SCALE) >> 32;
    atten = (sq >= Q16_ONE) ? 0 : Q16_ONE - sq;
    scaled = (mag * atten) >> 16;
    incr = (scaled * gain * step + STEP_DIV / 2) / STEP_DIV;
    total = longint'(acc) + ((e < 0) ? -longint'(incr) : longint'(incr));
    bound = limit;
    if (total > bound) total = bound;
    if (total < -bound) total = -bound;
    return integ_t'(total);
  endfunction

  function automatic logic [ERR_W-1:0] rand_err();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1, 2: v = $urandom_range(0, 2 * ERR_EDGE + 400) - ERR_EDGE - 200;
      default: v = $urandom_range(0, 4000) - 2000;
    endcase
    return v[ERR_W-1:0];
  endfunction

  function automatic logic [DT_W-1:0] rand_step();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? STEP_FULL : '0;
      1, 2, 3, 4: return DT_W'($urandom_range(0, 65535));
      default: return DT_W'($urandom_range(0, 5000));
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    return $urandom_range(0, 1) ? MASK_NONE : MASK_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAIN_FULL;
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LIM_FULL;
      2: return LIM_W'($urandom_range(LIM_MAX + 1, 131071));
      3, 4: return LIM_W'($urandom_range(1, 2000));
      default: return LIM_W'($urandom_range(0, LIM_MAX));
    endcase
  endfunction

  task automatic check_integ(input integ_vec_t got);
    integ_vec_t want;
    if (expected_integ.size() == 0) begin
      $error("unexpected result transaction %h", got);
      fail_count++;
    end else begin
      want = expected_integ.pop_front();
      for (int a = 0; a < AXES; a++) begin
        if (got[a] !== want[a]) begin
          $error("%s: expected %0d, got %0d", integ_name[a], $signed(want[a]),
                 $signed(got[a]));
          fail_count++;
        end
      end
    end
  endtask

  // result sink: random stalls per transaction, long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) begin
        check_integ(out_tdata[AXES*INTEG_W-1:0]);
        stall = $urandom_range(0, rx_stall_max);
      end
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_rates(input logic [ERR_W-1:0] e_roll, e_pitch, e_yaw,
                            input logic [MASK_W-1:0] pos_mask, neg_mask,
                            input logic [DT_W-1:0] step);
    int gap;
    integ_vec_t result;
    logic [ERR_W-1:0] errs [AXES];
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-IN_USED_W){1'b0}}, step, neg_mask, pos_mask,
                  e_yaw, e_pitch, e_roll};
    do @(posedge clk); while (in_tready !== 1'b1);
    errs[0] = e_roll;
    errs[1] = e_pitch;
    errs[2] = e_yaw;
    for (int a = 0; a < AXES; a++) begin
      integ_acc[a] = integrate_axis(integ_acc[a], errs[a], pos_mask[a], neg_mask[a],
                                    axis_gain[a], axis_limit[a], step);
      result[a] = integ_acc[a];
    end
    expected_integ.push_back(result);
  endtask

  task automatic send_random();
    send_rates(rand_err(), rand_err(), rand_err(), rand_mask(), rand_mask(), rand_step());
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_integ.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_GAIN_ROLL, CFG_GAIN_PITCH, CFG_GAIN_YAW:
        axis_gain[idx - CFG_GAIN_ROLL] = val[GAIN_W-1:0];
      CFG_LIM_ROLL, CFG_LIM_PITCH, CFG_LIM_YAW:
        axis_limit[idx - CFG_LIM_ROLL] = (val > LIM_MAX) ? LIM_W'(LIM_MAX) : val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [GAIN_W-1:0] g_roll, g_pitch, g_yaw,
                               input logic [LIM_W-1:0] l_roll, l_pitch, l_yaw);
    wait_idle();
    cfg_write(CFG_GAIN_ROLL, LIM_W'(g_roll));
    cfg_write(CFG_GAIN_PITCH, LIM_W'(g_pitch));
    cfg_write(CFG_GAIN_YAW, LIM_W'(g_yaw));
    cfg_write(CFG_LIM_ROLL, l_roll);
    cfg_write(CFG_LIM_PITCH, l_pitch);
    cfg_write(CFG_LIM_YAW, l_yaw);
    cfg_write(CFG_UNMAPPED_LO, LIM_W'($urandom));
    cfg_write(CFG_UNMAPPED_HI, LIM_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_rates(PEAK_ERR, -PEAK_ERR, PEAK_ERR, MASK_NONE, MASK_NONE, STEP_FULL);
    send_rates(ERR_TOP, ERR_BOTTOM, 1, MASK_NONE, MASK_ALL, STEP_FULL);
  endtask

  task automatic test_directed();
    load_settings(GAIN_FULL, GAIN_FULL, GAIN_FULL, LIM_FULL, LIM_FULL, LIM_FULL);
    send_rates(0, 0, 0, MASK_NONE, MASK_NONE, 1000);
    send_rates(PEAK_ERR, PEAK_ERR, PEAK_ERR, MASK_NONE, MASK_NONE, STEP_FULL);
    send_rates(-PEAK_ERR, -PEAK_ERR, -PEAK_ERR, MASK_NONE, MASK_NONE, STEP_FULL);
    send_rates(ERR_TOP, ERR_BOTTOM, ERR_TOP, MASK_NONE, MASK_NONE, STEP_FULL);
    send_rates(ERR_W'(ERR_EDGE), ERR_W'(ERR_EDGE + 1), ERR_W'(-ERR_EDGE), MASK_NONE,
               MASK_NONE, STEP_FULL);
    send_rates(1, -1, 0, MASK_NONE, MASK_NONE, STEP_FULL);
    send_rates(PEAK_ERR, PEAK_ERR, PEAK_ERR, MASK_ALL, MASK_NONE, STEP_FULL);
    send_rates(-PEAK_ERR, -PEAK_ERR, -PEAK_ERR, MASK_ALL, MASK_NONE, STEP_FULL);
    send_rates(-PEAK_ERR, -PEAK_ERR, -PEAK_ERR, MASK_NONE, MASK_ALL, STEP_FULL);
    send_rates(PEAK_ERR, PEAK_ERR, PEAK_ERR, MASK_NONE, MASK_ALL, STEP_FULL);
    send_rates(PEAK_ERR, -PEAK_ERR, ERR_TOP, MASK_ALL, MASK_ALL, STEP_FULL);
    send_rates(PEAK_ERR, PEAK_ERR, PEAK_ERR, MASK_NONE, MASK_NONE, 0);
    send_rates(-PEAK_ERR, PEAK_ERR, -PEAK_ERR, 3'b101, 3'b010, 20000);
  endtask

  task automatic test_limit_changes();
    load_settings(GAIN_FULL, 4096, 0, 100, LIM_RAW_TOP, LIM_FULL);
    send_rates(0, 0, 0, MASK_NONE, MASK_NONE, 0);
    send_rates(0, PEAK_ERR, -PEAK_ERR, MASK_NONE, MASK_NONE, STEP_FULL);
  endtask

  task automatic test_backpressure();
    load_settings(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit(),
                  rand_limit());
    tx_gap_max = 0;
    rx_hold = 4000;
    repeat (12) send_random();
    wait_idle();
    tx_gap_max = 8;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_settings(GAIN_FULL, GAIN_FULL, GAIN_FULL, LIM_FULL, LIM_FULL, LIM_FULL);
        3: load_settings(rand_gain(), rand_gain(), rand_gain(),
                         LIM_W'($urandom_range(0, 300)), LIM_W'($urandom_range(0, 300)),
                         LIM_W'($urandom_range(0, 300)));
        default: load_settings(rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                               rand_limit(), rand_limit());
      endcase
      tx_gap_max   = (phase == 1) ? 0 : 8;
      rx_stall_max = (phase == 1) ? 0 : 8;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_idle();
        send_random();
      end
    end
    tx_gap_max   = 8;
    rx_stall_max = 8;
  endtask

  initial begin
    for (int a = 0; a < AXES; a++) begin
      integ_acc[a]  = '0;
      axis_gain[a]  = '0;
      axis_limit[a] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_limit_changes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && expected_integ.size() == 0) begin
      $display("rate_integrator_antiwindup_top: match");
    end else begin
      $display("rate_integrator_antiwindup_top: mismatch");
    end
    $finish;
  end

endmodule
